[hw/rtl/rmq_pkg.sv]
// Shared widths, pipeline sideband type and component codes for the
// rotation-matrix-to-quaternion core. No dependencies.
`default_nettype none
package rmq_pkg;

  localparam int FracBits = 14;
  localparam int DataW    = 16;
  localparam int NumLanes = 3;

  // radicand: below 3*2^15 + 2^FracBits; non-positive ones are flagged invalid
  localparam int RadW  = ((FracBits > 17) ? FracBits : 17) + 2;
  localparam int RootInW = RadW + FracBits + ((RadW + FracBits) % 2);
  localparam int RootW = RootInW / 2;
  localparam int SqRemW = RootW + 3;

  // divider: magnitude of an element sum is at most 2^16
  localparam int MagW  = DataW + 1;
  localparam int NumW  = MagW + FracBits + 1;
  localparam int DenW  = RootW + 1;
  localparam int QuoW  = DataW - 1;
  localparam int CmpW  = NumW + DenW + QuoW;

  localparam logic [1:0] CompX = 2'd0;
  localparam logic [1:0] CompY = 2'd1;
  localparam logic [1:0] CompZ = 2'd2;
  localparam logic [1:0] CompW = 2'd3;

  typedef struct packed {
    logic                valid;
    logic                invalid;
    logic [1:0]          root_sel;
    logic [NumLanes-1:0] neg;
  } meta_t;

endpackage
`default_nettype wire

[hw/rtl/rmq_prep.sv]
// Input stage: trace test, largest-diagonal pick, radicand and lane numerators.
// Depends on rmq_pkg.
`default_nettype none
module rmq_prep import rmq_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    adv_i,
  input  wire logic                    valid_i,
  input  wire logic signed [DataW-1:0] m00_i,
  input  wire logic signed [DataW-1:0] m01_i,
  input  wire logic signed [DataW-1:0] m02_i,
  input  wire logic signed [DataW-1:0] m10_i,
  input  wire logic signed [DataW-1:0] m11_i,
  input  wire logic signed [DataW-1:0] m12_i,
  input  wire logic signed [DataW-1:0] m20_i,
  input  wire logic signed [DataW-1:0] m21_i,
  input  wire logic signed [DataW-1:0] m22_i,
  output meta_t                        meta_o,
  output logic [RootInW-1:0]           rad_o,
  output logic [NumLanes-1:0][MagW-1:0] mag_o
);

  localparam int SW = RadW + 1;

  meta_t meta_d, meta_q;
  logic [RootInW-1:0] rad_d, rad_q;
  logic [NumLanes-1:0][MagW-1:0] mag_d, mag_q;

  logic signed [SW-1:0] e00, e11, e22, trace, rad_s, one;
  logic signed [MagW-1:0] n [NumLanes];

  always_comb begin
    one   = SW'(1) <<< FracBits;
    e00   = SW'(m00_i);
    e11   = SW'(m11_i);
    e22   = SW'(m22_i);
    trace = e00 + e11 + e22;
    meta_d = '0;
    meta_d.valid = valid_i;
    if (trace > 0) begin
      meta_d.root_sel = CompW;
      rad_s = trace + one;
      n[0] = MagW'(m12_i) - MagW'(m21_i);
      n[1] = MagW'(m20_i) - MagW'(m02_i);
      n[2] = MagW'(m01_i) - MagW'(m10_i);
    end else if ((m22_i > m11_i) && (m22_i > m00_i) ||
                 (m22_i > m00_i) && !(m11_i > m00_i)) begin
      // largest z: lanes x, y, w
      meta_d.root_sel = CompZ;
      rad_s = e22 - e00 - e11 + one;
      n[0] = MagW'(m20_i) + MagW'(m02_i);
      n[1] = MagW'(m21_i) + MagW'(m12_i);
      n[2] = MagW'(m01_i) - MagW'(m10_i);
    end else if (m11_i > m00_i) begin
      // largest y: lanes x, z, w
      meta_d.root_sel = CompY;
      rad_s = e11 - e22 - e00 + one;
      n[0] = MagW'(m10_i) + MagW'(m01_i);
      n[1] = MagW'(m12_i) + MagW'(m21_i);
      n[2] = MagW'(m20_i) - MagW'(m02_i);
    end else begin
      // largest x: lanes y, z, w
      meta_d.root_sel = CompX;
      rad_s = e00 - e11 - e22 + one;
      n[0] = MagW'(m01_i) + MagW'(m10_i);
      n[1] = MagW'(m02_i) + MagW'(m20_i);
      n[2] = MagW'(m12_i) - MagW'(m21_i);
    end
    meta_d.invalid = (rad_s <= 0);
    rad_d = RootInW'(rad_s[RadW-1:0]) << FracBits;
    for (int l = 0; l < NumLanes; l++) begin
      meta_d.neg[l] = n[l][MagW-1];
      mag_d[l] = n[l][MagW-1] ? MagW'(-n[l]) : MagW'(n[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (adv_i) begin
      meta_q <= meta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rad_q <= rad_d;
      mag_q <= mag_d;
    end
  end

  assign meta_o = meta_q;
  assign rad_o  = rad_q;
  assign mag_o  = mag_q;

endmodule
`default_nettype wire

[hw/rtl/rmq_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on rmq_pkg.
`default_nettype none
module rmq_sqrt_pipe import rmq_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     adv_i,
  input  wire meta_t                    meta_i,
  input  wire logic [RootInW-1:0]       rad_i,
  input  wire logic [NumLanes-1:0][MagW-1:0] mag_i,
  output meta_t                         meta_o,
  output logic [RootW-1:0]              root_o,
  output logic [NumLanes-1:0][MagW-1:0] mag_o
);

  meta_t                         meta_q [RootW];
  logic [SqRemW-1:0]             rem_q  [RootW];
  logic [RootW-1:0]              root_q [RootW];
  logic [RootInW-1:0]            rad_q  [RootW];
  logic [NumLanes-1:0][MagW-1:0] mag_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    meta_t                         meta_p;
    logic [SqRemW-1:0]             rem_p, rem_sh, trial, rem_d;
    logic [RootW-1:0]              root_p, root_d;
    logic [RootInW-1:0]            rad_p;
    logic [NumLanes-1:0][MagW-1:0] mag_p;

    if (k == 0) begin : g_first
      assign meta_p = meta_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
      assign mag_p  = mag_i;
    end else begin : g_next
      assign meta_p = meta_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign mag_p  = mag_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_p[SqRemW-3:0], rad_p[RootInW-1 -: 2]};
      trial  = SqRemW'({root_p, 2'b01});
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_p[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_p[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[k] <= '0;
      end else if (adv_i) begin
        meta_q[k] <= meta_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= rad_p << 2;
        mag_q[k]  <= mag_p;
      end
    end
  end

  assign meta_o = meta_q[RootW-1];
  assign root_o = root_q[RootW-1];
  assign mag_o  = mag_q[RootW-1];

endmodule
`default_nettype wire

[hw/rtl/rmq_div_pipe.sv]
// Pipelined rounded divide of three lane magnitudes by twice the root,
// overflow check stage then one quotient bit per stage. Depends on rmq_pkg.
`default_nettype none
module rmq_div_pipe import rmq_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     adv_i,
  input  wire meta_t                    meta_i,
  input  wire logic [RootW-1:0]         root_i,
  input  wire logic [NumLanes-1:0][MagW-1:0] mag_i,
  output meta_t                         meta_o,
  output logic [RootW-1:0]              root_o,
  output logic [NumLanes-1:0][QuoW-1:0] quo_o,
  output logic [NumLanes-1:0]           ovf_o
);

  localparam int Stages = QuoW + 1;

  meta_t                         meta_q [Stages];
  logic [RootW-1:0]              root_q [Stages];
  logic [DenW-1:0]               den_q  [Stages];
  logic [NumLanes-1:0][DenW-1:0] rem_q  [Stages];
  logic [NumLanes-1:0][QuoW-1:0] low_q  [Stages];
  logic [NumLanes-1:0][QuoW-1:0] quo_q  [Stages];
  logic [NumLanes-1:0]           ovf_q  [Stages];

  // setup: numerator with half-divisor rounding, overflow test
  logic [NumLanes-1:0][DenW-1:0] rem0;
  logic [NumLanes-1:0][QuoW-1:0] low0;
  logic [NumLanes-1:0]           ovf0;
  logic [DenW-1:0]               den0;

  always_comb begin
    logic [NumW-1:0] num;
    den0 = {root_i, 1'b0};
    for (int l = 0; l < NumLanes; l++) begin
      num = (NumW'(mag_i[l]) << FracBits) + NumW'(root_i);
      ovf0[l] = CmpW'(num) >= (CmpW'(den0) << QuoW);
      rem0[l] = DenW'(num[NumW-1:QuoW]);
      low0[l] = num[QuoW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q[0] <= '0;
    end else if (adv_i) begin
      meta_q[0] <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      root_q[0] <= root_i;
      den_q[0]  <= den0;
      rem_q[0]  <= rem0;
      low_q[0]  <= low0;
      quo_q[0]  <= '0;
      ovf_q[0]  <= ovf0;
    end
  end

  for (genvar k = 1; k < Stages; k++) begin : g_stage
    logic [NumLanes-1:0][DenW-1:0] rem_d;
    logic [NumLanes-1:0][QuoW-1:0] quo_d;

    always_comb begin
      logic [DenW:0] rem_sh;
      for (int l = 0; l < NumLanes; l++) begin
        rem_sh = {rem_q[k-1][l], low_q[k-1][l][QuoW-1]};
        if (rem_sh >= {1'b0, den_q[k-1]}) begin
          rem_d[l] = DenW'(rem_sh - {1'b0, den_q[k-1]});
          quo_d[l] = {quo_q[k-1][l][QuoW-2:0], 1'b1};
        end else begin
          rem_d[l] = rem_sh[DenW-1:0];
          quo_d[l] = {quo_q[k-1][l][QuoW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[k] <= '0;
      end else if (adv_i) begin
        meta_q[k] <= meta_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        root_q[k] <= root_q[k-1];
        den_q[k]  <= den_q[k-1];
        rem_q[k]  <= rem_d;
        for (int l = 0; l < NumLanes; l++) begin
          low_q[k][l] <= low_q[k-1][l] << 1;
        end
        quo_q[k]  <= quo_d;
        ovf_q[k]  <= ovf_q[k-1];
      end
    end
  end

  assign meta_o = meta_q[Stages-1];
  assign root_o = root_q[Stages-1];
  assign quo_o  = quo_q[Stages-1];
  assign ovf_o  = ovf_q[Stages-1];

endmodule
`default_nettype wire

[hw/rtl/rotation_matrix_to_quaternion_core.sv]
// Signed Q1.14 data. Throughput: one matrix per cycle unless the output stalls;
// every stage is a register, the square root retires one bit per stage and
// each divider lane one quotient bit per stage.
// All stages advance together whenever the output register is empty or taken.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; data is not reset.
// Depends on rmq_pkg, rmq_prep, rmq_sqrt_pipe, rmq_div_pipe.
`default_nettype none
module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic signed [DataW-1:0] m00_i,
  input  wire logic signed [DataW-1:0] m01_i,
  input  wire logic signed [DataW-1:0] m02_i,
  input  wire logic signed [DataW-1:0] m10_i,
  input  wire logic signed [DataW-1:0] m11_i,
  input  wire logic signed [DataW-1:0] m12_i,
  input  wire logic signed [DataW-1:0] m20_i,
  input  wire logic signed [DataW-1:0] m21_i,
  input  wire logic signed [DataW-1:0] m22_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [DataW-1:0]      qx_o,
  output logic signed [DataW-1:0]      qy_o,
  output logic signed [DataW-1:0]      qz_o,
  output logic signed [DataW-1:0]      qw_o,
  output logic                         invalid_o
);

  // Advance the whole pipe when the output slot is free or being drained;
  // otherwise hold every stage so no beat is dropped or duplicated.
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  meta_t                         prep_meta, sq_meta, dv_meta;
  logic [RootInW-1:0]            prep_rad;
  logic [NumLanes-1:0][MagW-1:0] prep_mag, sq_mag;
  logic [RootW-1:0]              sq_root, dv_root;
  logic [NumLanes-1:0][QuoW-1:0] dv_quo;
  logic [NumLanes-1:0]           dv_ovf;

  rmq_prep u_prep (
    .clk_i, .rst_ni,
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .m00_i, .m01_i, .m02_i, .m10_i, .m11_i, .m12_i, .m20_i, .m21_i, .m22_i,
    .meta_o  (prep_meta),
    .rad_o   (prep_rad),
    .mag_o   (prep_mag)
  );

  rmq_sqrt_pipe u_sqrt (
    .clk_i, .rst_ni,
    .adv_i  (adv),
    .meta_i (prep_meta),
    .rad_i  (prep_rad),
    .mag_i  (prep_mag),
    .meta_o (sq_meta),
    .root_o (sq_root),
    .mag_o  (sq_mag)
  );

  rmq_div_pipe u_div (
    .clk_i, .rst_ni,
    .adv_i  (adv),
    .meta_i (sq_meta),
    .root_i (sq_root),
    .mag_i  (sq_mag),
    .meta_o (dv_meta),
    .root_o (dv_root),
    .quo_o  (dv_quo),
    .ovf_o  (dv_ovf)
  );

  // Final assembly: sign and saturate lanes, round the root half up,
  // then steer lanes around the component that takes the root.
  logic [NumLanes-1:0][DataW-1:0] lane_val;
  logic [RootW:0]                 half_root;
  logic [DataW-1:0]               root_val;
  logic [3:0][DataW-1:0]          comp_d;

  always_comb begin
    half_root = ({1'b0, dv_root} + (RootW+1)'(1)) >> 1;
    if (half_root > (RootW+1)'(2**(DataW-1) - 1)) begin
      root_val = DataW'(2**(DataW-1) - 1);
    end else begin
      root_val = half_root[DataW-1:0];
    end
    for (int l = 0; l < NumLanes; l++) begin
      if (dv_ovf[l]) begin
        lane_val[l] = dv_meta.neg[l] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
      end else begin
        lane_val[l] = dv_meta.neg[l] ? DataW'(-{1'b0, dv_quo[l]}) : {1'b0, dv_quo[l]};
      end
    end
    if (dv_meta.invalid) begin
      comp_d = '0;
    end else begin
      // lanes fill the components below the root one first, in order
      comp_d[CompX] = lane_val[0];
      comp_d[CompY] = (dv_meta.root_sel == CompX) ? lane_val[0] : lane_val[1];
      comp_d[CompZ] = (dv_meta.root_sel == CompW) ? lane_val[2] : lane_val[1];
      comp_d[CompW] = lane_val[2];
      comp_d[dv_meta.root_sel] = root_val;
    end
  end

  logic                  out_valid_q;
  logic [3:0][DataW-1:0] comp_q;
  logic                  invalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_meta.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      comp_q    <= comp_d;
      invalid_q <= dv_meta.invalid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign qx_o        = comp_q[CompX];
  assign qy_o        = comp_q[CompY];
  assign qz_o        = comp_q[CompZ];
  assign qw_o        = comp_q[CompW];
  assign invalid_o   = invalid_q;

`ifndef SYNTHESIS
  // A rejected radicand must come out as an all-zero quaternion.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> qx_o == 0 && qy_o == 0 && qz_o == 0 && qw_o == 0)
    else $error("invalid result carries nonzero components");

  // A valid result always has at least one positive component, as the root one is.
  a_root_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !invalid_o |-> qx_o > 0 || qy_o > 0 || qz_o > 0 || qw_o > 0)
    else $error("valid result without positive root component");

  // While the output is stalled the last divider stage must be held too.
  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(dv_meta) && $stable(dv_quo))
    else $error("pipeline moved during output stall");
`endif

endmodule
`default_nettype wire
